// ===== rtl/core/ptt_pkg.sv =====
// ============================================================================
// ptt_pkg
// Shared types and codes for the page table / TLB address translator.
// ============================================================================
package ptt_pkg;

    // Fixed field widths
    localparam int VA_W   = 32;
    localparam int VPG_W  = 25;
    localparam int PPG_W  = 16;
    localparam int PA_W   = 23;
    localparam int LTS_W  = 6;
    localparam int PPC_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Item kinds
    localparam logic [1:0] MODE_XLATE = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // Alignment masks
    localparam logic [1:0] HALF_MASK = 2'h1;
    localparam logic [1:0] WORD_MASK = 2'h3;

    // Fault codes
    localparam logic [2:0] FAULT_NONE = 3'd0;
    localparam logic [2:0] FAULT_ADDR = 3'd1;
    localparam logic [2:0] FAULT_PAGE = 3'd2;
    localparam logic [2:0] FAULT_RO   = 3'd3;
    localparam logic [2:0] FAULT_BUS  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_PAGES  = 2'd2;

    // Configuration reset values
    localparam logic [LTS_W-1:0] LTS_RESET = 6'd32;
    localparam logic [PPC_W-1:0] PPC_RESET = 17'd32;

    typedef struct packed {
        logic [1:0]       mode;
        logic [VA_W-1:0]  virt_addr;
        logic [1:0]       access_size;
        logic             write_access;
        logic [4:0]       entry_index;
        logic             new_valid;
        logic             new_read_only;
        logic             new_use;
        logic             new_dirty;
        logic [VPG_W-1:0] new_virtual_page;
        logic [PPG_W-1:0] new_physical_page;
    } t_req;

    typedef struct packed {
        logic [2:0]       fault_code;
        logic [PA_W-1:0]  phys_addr;
        logic             got_valid;
        logic             got_read_only;
        logic             got_use;
        logic             got_dirty;
        logic [VPG_W-1:0] got_virtual_page;
        logic [PPG_W-1:0] got_physical_page;
    } t_rsp;

    // One translation table entry (45 bits)
    typedef struct packed {
        logic             valid;
        logic             read_only;
        logic             used;
        logic             dirty;
        logic [VPG_W-1:0] virtual_page;
        logic [PPG_W-1:0] physical_page;
    } t_entry;

    typedef struct packed {
        logic             lookup_mode;
        logic [LTS_W-1:0] linear_table_size;
        logic [PPC_W-1:0] phys_page_count;
    } t_cfg;

    // Table port enables
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/ptt_req_if.sv =====
// ============================================================================
// ptt_req_if
// Request channel: valid/ready handshake carrying one input transaction.
// ============================================================================
interface ptt_req_if;
    logic          valid;
    logic          ready;
    ptt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptt_rsp_if.sv =====
// ============================================================================
// ptt_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ============================================================================
interface ptt_rsp_if;
    logic          valid;
    logic          ready;
    ptt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ptt_table.sv =====
// ============================================================================
// ptt_table
// Translation table storage: single-port-read, single-port-write synchronous
// memory with registered read data and per-entry written flags.
// ============================================================================
module ptt_table #(
    parameter int ENTRIES = 32,
    parameter int IDX_W   = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptt_pkg::t_tbl_ctl    i_ctl,
    input  logic [IDX_W-1:0]     i_rd_addr,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  ptt_pkg::t_entry      i_wr_data,
    output ptt_pkg::t_entry      o_rd_data
);
    import ptt_pkg::*;

    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_written;
    t_entry               r_rd_data;
    logic                 r_rd_init;

    // Memory array and read data register
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written flags: an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_init <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_init ? r_rd_data : '0;

endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// ============================================================================
// ptt_ctrl
// Transaction sequencer: checks, table lookup and scan, use/dirty
// write-back, and the output register.
// ============================================================================
module ptt_ctrl #(
    parameter int TABLE_ENTRIES = 32,
    parameter int PAGE_BYTES    = 128,
    parameter int IDX_W         = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptt_pkg::t_cfg        i_cfg,
    ptt_req_if.sink              i_req,
    ptt_rsp_if.source            o_rsp,
    output ptt_pkg::t_tbl_ctl    o_tbl_ctl,
    output logic [IDX_W-1:0]     o_tbl_rd_addr,
    output logic [IDX_W-1:0]     o_tbl_wr_addr,
    output ptt_pkg::t_entry      o_tbl_wr_data,
    input  ptt_pkg::t_entry      i_tbl_rd_data
);
    import ptt_pkg::*;

    // PAGE_BYTES is a power of two: page number and offset are bit fields
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int VPN_W      = VA_W - PAGE_SHIFT;
    localparam logic [31:0]      ENT32    = 32'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state                r_state, n_state;
    logic [VPN_W-1:0]      r_vpn, n_vpn;
    logic [PAGE_SHIFT-1:0] r_off, n_off;
    logic                  r_wr, n_wr;
    logic                  r_assoc, n_assoc;
    logic [IDX_W-1:0]      r_addr, n_addr;
    t_rsp                  r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic [31:0] vpn32;
    logic [31:0] idx32;
    logic [31:0] lim32;
    logic        misalign;
    logic        hit;
    logic        last;
    t_entry      ent;
    logic        out_free;

    // Input decode
    assign vpn32 = i_req.data.virt_addr >> PAGE_SHIFT;
    assign idx32 = 32'(i_req.data.entry_index);
    assign lim32 = (32'(i_cfg.linear_table_size) > ENT32) ? ENT32
                                                          : 32'(i_cfg.linear_table_size);
    assign misalign =
        ((i_req.data.access_size != SIZE_BYTE) && (i_req.data.access_size != SIZE_HALF)
            && ((i_req.data.virt_addr[1:0] & WORD_MASK) != 2'b00))
        || ((i_req.data.access_size == SIZE_HALF)
            && ((i_req.data.virt_addr[1:0] & HALF_MASK) != 2'b00));

    // Entry compare on returned read data
    assign ent  = i_tbl_rd_data;
    assign hit  = ent.valid && (!r_assoc || (32'(r_vpn) == 32'(ent.virtual_page)));
    assign last = !r_assoc || (r_addr == LAST_IDX);
    assign out_free = !r_out_valid || o_rsp.ready;

    // Next state and table access
    always_comb begin
        n_state       = r_state;
        n_vpn         = r_vpn;
        n_off         = r_off;
        n_wr          = r_wr;
        n_assoc       = r_assoc;
        n_addr        = r_addr;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out         = r_out;
        i_req.ready   = 1'b0;
        o_tbl_ctl     = '0;
        o_tbl_rd_addr = r_addr;
        o_tbl_wr_addr = r_addr;
        o_tbl_wr_data = ent;

        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_vpn   = vpn32[VPN_W-1:0];
                    n_off   = i_req.data.virt_addr[PAGE_SHIFT-1:0];
                    n_wr    = i_req.data.write_access;
                    n_assoc = i_cfg.lookup_mode;
                    n_res   = '0;
                    n_state = ST_DONE;
                    unique case (i_req.data.mode)
                        MODE_XLATE: begin
                            if (misalign) begin
                                n_res.fault_code = FAULT_ADDR;
                            end else if (i_cfg.lookup_mode) begin
                                // Scan starts at entry zero
                                o_tbl_ctl.rd_en = 1'b1;
                                o_tbl_rd_addr   = '0;
                                n_addr          = '0;
                                n_state         = ST_LOOK;
                            end else if (vpn32 >= lim32) begin
                                n_res.fault_code = FAULT_ADDR;
                            end else begin
                                o_tbl_ctl.rd_en = 1'b1;
                                o_tbl_rd_addr   = vpn32[IDX_W-1:0];
                                n_addr          = vpn32[IDX_W-1:0];
                                n_state         = ST_LOOK;
                            end
                        end
                        MODE_WRITE: begin
                            if (idx32 < ENT32) begin
                                o_tbl_ctl.wr_en             = 1'b1;
                                o_tbl_wr_addr               = idx32[IDX_W-1:0];
                                o_tbl_wr_data.valid         = i_req.data.new_valid;
                                o_tbl_wr_data.read_only     = i_req.data.new_read_only;
                                o_tbl_wr_data.used          = i_req.data.new_use;
                                o_tbl_wr_data.dirty         = i_req.data.new_dirty;
                                o_tbl_wr_data.virtual_page  = i_req.data.new_virtual_page;
                                o_tbl_wr_data.physical_page = i_req.data.new_physical_page;
                            end
                        end
                        MODE_READ: begin
                            if (idx32 < ENT32) begin
                                o_tbl_ctl.rd_en = 1'b1;
                                o_tbl_rd_addr   = idx32[IDX_W-1:0];
                                n_state         = ST_READ;
                            end
                        end
                        default: begin
                            // Unused mode: all-zero result
                        end
                    endcase
                end
            end

            ST_LOOK: begin
                if (hit) begin
                    n_state = ST_DONE;
                    if (ent.read_only && r_wr) begin
                        n_res.fault_code = FAULT_RO;
                    end else if ({1'b0, ent.physical_page} >= i_cfg.phys_page_count) begin
                        n_res.fault_code = FAULT_BUS;
                    end else begin
                        // Write back with use and dirty marks updated
                        o_tbl_ctl.wr_en     = 1'b1;
                        o_tbl_wr_data.used  = 1'b1;
                        o_tbl_wr_data.dirty = ent.dirty || r_wr;
                        n_res.fault_code    = FAULT_NONE;
                        n_res.phys_addr     = PA_W'({ent.physical_page, r_off});
                    end
                end else if (last) begin
                    n_res.fault_code = FAULT_PAGE;
                    n_state          = ST_DONE;
                end else begin
                    // Next entry of the associative scan
                    o_tbl_ctl.rd_en = 1'b1;
                    o_tbl_rd_addr   = r_addr + IDX_W'(1);
                    n_addr          = r_addr + IDX_W'(1);
                end
            end

            ST_READ: begin
                n_res.got_valid         = ent.valid;
                n_res.got_read_only     = ent.read_only;
                n_res.got_use           = ent.used;
                n_res.got_dirty         = ent.dirty;
                n_res.got_virtual_page  = ent.virtual_page;
                n_res.got_physical_page = ent.physical_page;
                n_state                 = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_vpn   <= n_vpn;
        r_off   <= n_off;
        r_wr    <= n_wr;
        r_assoc <= n_assoc;
        r_addr  <= n_addr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// ===== rtl/core/page_table_tlb_address_translator_top.sv =====
// Page table / TLB address translator. One transaction is handled at a time;
// its result goes to an output register, so the next request is taken while
// a result still waits to be read. Entry writes, unused modes and alignment
// or range faults go straight to the result; entry reads and linear-mode
// translations first read the addressed entry; an associative translation
// scans from entry zero until a hit or the last entry. The associative
// search reads one entry per cycle from the single read port of the table
// memory; a hit with no fault writes the use and dirty marks back in the
// cycle that evaluates it. The table needs no clearing pass after reset.
// PAGE_BYTES must be a power of two.
// ============================================================================
// page_table_tlb_address_translator_top
// Top level: configuration registers, table memory and sequencer.
// ============================================================================
module page_table_tlb_address_translator_top #(
    parameter int TABLE_ENTRIES = 32,
    parameter int PAGE_BYTES    = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ptt_req_if.sink                           i_req,
    ptt_rsp_if.source                         o_rsp
);
    import ptt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_cfg             r_cfg;
    t_tbl_ctl         tbl_ctl;
    logic [IDX_W-1:0] tbl_rd_addr;
    logic [IDX_W-1:0] tbl_wr_addr;
    t_entry           tbl_wr_data;
    t_entry           tbl_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lookup_mode       <= 1'b0;
            r_cfg.linear_table_size <= LTS_RESET;
            r_cfg.phys_page_count   <= PPC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOOKUP_MODE: r_cfg.lookup_mode       <= i_cfg_data[0];
                CFG_LINEAR_SIZE: r_cfg.linear_table_size <= i_cfg_data[LTS_W-1:0];
                CFG_PHYS_PAGES:  r_cfg.phys_page_count   <= i_cfg_data[PPC_W-1:0];
                default: begin
                    // Index beyond the register list: ignored
                end
            endcase
        end
    end

    // Transaction sequencer
    ptt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_BYTES    (PAGE_BYTES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_tbl_ctl     (tbl_ctl),
        .o_tbl_rd_addr (tbl_rd_addr),
        .o_tbl_wr_addr (tbl_wr_addr),
        .o_tbl_wr_data (tbl_wr_data),
        .i_tbl_rd_data (tbl_rd_data)
    );

    // Translation table memory
    ptt_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (tbl_ctl),
        .i_rd_addr (tbl_rd_addr),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .o_rd_data (tbl_rd_data)
    );

endmodule
